[hw/rtl/mss_pkg.sv]
// Shared types, constants and a helper function for the Morton split search block.
`default_nettype none
package mss_pkg;

    localparam int IDX_W   = 10;
    localparam int CODE_W  = 32;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int LIMIT_W = 17;

    typedef enum logic [0:0] {
        A_LOAD  = 1'b0,
        A_QUERY = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        K_LOAD,
        K_QUERY,
        K_NOSPLIT
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  idx_a;
        logic [IDX_W-1:0]  idx_b;
        logic [CODE_W-1:0] code;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_PREFIX,
        S_SEARCH,
        S_DONE
    } t_state;

    // Set every bit at or below the highest set bit
    function automatic logic [CODE_W-1:0] f_smear(input logic [CODE_W-1:0] v);
        logic [CODE_W-1:0] s;
        s = v;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/mss_front.sv]
// Front end: accepts items, classifies them and forms queue commands.
`default_nettype none
module mss_front
    import mss_pkg::*;
#(
    parameter int MAX_PRIMS = 1024
) (
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire logic              i_action,
    input  wire logic [IDX_W-1:0]  i_load_index,
    input  wire logic [CODE_W-1:0] i_load_code,
    input  wire logic [IDX_W-1:0]  i_range_first,
    input  wire logic [IDX_W-1:0]  i_range_last,
    input  wire logic              i_q_full,
    output      logic              o_push,
    output      t_cmd              o_cmd
);

    localparam logic [LIMIT_W-1:0] LIMIT = LIMIT_W'(MAX_PRIMS);

    logic load_ok;
    logic range_ok;

    assign o_ready  = !i_q_full;
    assign load_ok  = LIMIT_W'(i_load_index) < LIMIT;
    assign range_ok = (i_range_first < i_range_last) && (LIMIT_W'(i_range_last) < LIMIT);

    // Classify the item; drop loads beyond the store
    always_comb begin
        o_cmd.code = i_load_code;
        o_push     = i_valid && o_ready;
        if (t_action'(i_action) == A_LOAD) begin
            o_cmd.kind  = K_LOAD;
            o_cmd.idx_a = i_load_index;
            o_cmd.idx_b = i_range_last;
            o_push      = i_valid && o_ready && load_ok;
        end else begin
            o_cmd.kind  = range_ok ? K_QUERY : K_NOSPLIT;
            o_cmd.idx_a = i_range_first;
            o_cmd.idx_b = i_range_last;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/mss_queue.sv]
// Short command queue between the front end and the search engine.
`default_nettype none
module mss_queue
    import mss_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output      logic o_full,
    input  wire logic i_pop,
    output      logic o_valid,
    output      t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/mss_back.sv]
// Back end: code store, prefix compare and halving search sequencer.
`default_nettype none
module mss_back
    import mss_pkg::*;
#(
    parameter int MAX_PRIMS = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire t_cmd             i_cmd,
    output      logic             o_cmd_pop,
    output      logic             o_valid,
    input  wire logic             i_ready,
    output      logic [IDX_W-1:0] o_split_index,
    output      logic             o_no_split
);

    localparam int AW = $clog2(MAX_PRIMS);

    logic [CODE_W-1:0] r_store [MAX_PRIMS];

    t_state            r_state,   n_state;
    logic [CODE_W-1:0] r_head,    n_head;
    logic [CODE_W-1:0] r_mask,    n_mask;
    logic [IDX_W-1:0]  r_last,    n_last;
    logic [IDX_W-1:0]  r_split,   n_split;
    logic [IDX_W-1:0]  r_step,    n_step;
    logic [IDX_W-1:0]  r_probe,   n_probe;
    logic              r_pend,    n_pend;
    logic [IDX_W-1:0]  r_res_idx, n_res_idx;
    logic              r_res_ns,  n_res_ns;
    logic [CODE_W-1:0] r_rdata;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_ns;

    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic              out_load;
    logic              match;
    logic [IDX_W-1:0]  cur_split;
    logic [IDX_W-1:0]  step_nx;
    logic [IDX_W:0]    probe_w;
    logic [CODE_W-1:0] diff;

    // Probe datapath
    assign match     = ((r_head ^ r_rdata) & r_mask) == '0;
    assign cur_split = (r_pend && match) ? r_probe : r_split;
    assign step_nx   = IDX_W'(((IDX_W + 1)'(1) + (IDX_W + 1)'(r_step)) >> 1);
    assign probe_w   = (IDX_W + 1)'(cur_split) + (IDX_W + 1)'(step_nx);
    assign diff      = r_head ^ r_rdata;

    // Next state and sequencer outputs
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_mask    = r_mask;
        n_last    = r_last;
        n_split   = r_split;
        n_step    = r_step;
        n_probe   = r_probe;
        n_pend    = r_pend;
        n_res_idx = r_res_idx;
        n_res_ns  = r_res_ns;
        o_cmd_pop = 1'b0;
        wr_en     = 1'b0;
        out_load  = 1'b0;
        rd_addr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        K_LOAD: begin
                            wr_en = 1'b1;
                        end
                        K_QUERY: begin
                            rd_addr = AW'(i_cmd.idx_a);
                            n_last  = i_cmd.idx_b;
                            n_split = i_cmd.idx_a;
                            n_step  = i_cmd.idx_b - i_cmd.idx_a;
                            n_state = S_HEAD;
                        end
                        default: begin
                            n_res_idx = '0;
                            n_res_ns  = 1'b1;
                            n_state   = S_DONE;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                n_head  = r_rdata;
                rd_addr = AW'(r_last);
                n_state = S_PREFIX;
            end
            S_PREFIX: begin
                if (diff == '0) begin
                    n_res_idx = '0;
                    n_res_ns  = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    // Keep the common prefix plus the first differing bit
                    n_mask  = ~(f_smear(diff) >> 1);
                    n_pend  = 1'b0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_step <= IDX_W'(1)) begin
                    n_res_idx = cur_split;
                    n_res_ns  = 1'b0;
                    n_state   = S_DONE;
                end else begin
                    n_split = cur_split;
                    n_step  = step_nx;
                    n_probe = probe_w[IDX_W-1:0];
                    n_pend  = probe_w < (IDX_W + 1)'(r_last);
                    rd_addr = AW'(probe_w[IDX_W-1:0]);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_head    <= n_head;
        r_mask    <= n_mask;
        r_last    <= n_last;
        r_split   <= n_split;
        r_step    <= n_step;
        r_probe   <= n_probe;
        r_pend    <= n_pend;
        r_res_idx <= n_res_idx;
        r_res_ns  <= n_res_ns;
        if (out_load) begin
            r_out_idx <= r_res_idx;
            r_out_ns  <= r_res_ns;
        end
    end

    // Code store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[AW'(i_cmd.idx_a)] <= i_cmd.code;
        end
        r_rdata <= r_store[rd_addr];
    end

    assign o_valid       = r_out_valid;
    assign o_split_index = r_out_idx;
    assign o_no_split    = r_out_ns;

endmodule
`default_nettype wire

[hw/rtl/morton_split_search.sv]
// Flow: a load passes through the queue and is written to the store when the idle
//   sequencer pops it; a query reads the head and last codes through the single store read
//   port, then runs the dependent chain of halving probes (a bad or single-element range,
//   or identical end codes, skip the probes); a busy engine or held output delays both.
// Throughput: one load per cycle while the queue is not full; queries run one at a time behind a 2-entry queue.
// Reset: synchronous, active low; clears queue, sequencer and output valid, not the store.
`default_nettype none
module morton_split_search
    import mss_pkg::*;
#(
    parameter int MAX_PRIMS = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire logic              i_action,
    input  wire logic [IDX_W-1:0]  i_load_index,
    input  wire logic [CODE_W-1:0] i_load_code,
    input  wire logic [IDX_W-1:0]  i_range_first,
    input  wire logic [IDX_W-1:0]  i_range_last,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      logic [IDX_W-1:0]  o_split_index,
    output      logic              o_no_split
);

    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_valid;
    logic q_pop;
    t_cmd q_out;

    mss_front #(
        .MAX_PRIMS(MAX_PRIMS)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_load_index (i_load_index),
        .i_load_code  (i_load_code),
        .i_range_first(i_range_first),
        .i_range_last (i_range_last),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in)
    );

    mss_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_cmd  (q_out)
    );

    mss_back #(
        .MAX_PRIMS(MAX_PRIMS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_out),
        .o_cmd_pop    (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_split_index(o_split_index),
        .o_no_split   (o_no_split)
    );

endmodule
`default_nettype wire

[tb/split_tracker_pkg.sv]
// Expected-result tracker for the Morton split search testbench: code store copy and split predictor.
`timescale 1ns / 1ps
package split_tracker_pkg;
    import mss_pkg::*;

    localparam int NUM_ENTRIES  = 1 << IDX_W;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [IDX_W-1:0] split_index;
        logic             no_split;
    } t_split_res;

    class split_tracker;
        logic [CODE_W-1:0] codes [NUM_ENTRIES];
        bit                written [NUM_ENTRIES];
        t_split_res        pending_splits [$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       loads;
        int unsigned       queries;
        int unsigned       splits;
        int unsigned       quiet;

        // Count zero bits above the highest set bit
        function int unsigned lead_zeros(logic [CODE_W-1:0] v);
            for (int i = CODE_W - 1; i >= 0; i--) begin
                if (v[i]) begin
                    return CODE_W - 1 - i;
                end
            end
            return CODE_W;
        endfunction

        // Halving search for the last index that shares prefix + 1 bits with the head code
        function t_split_res predict_split(logic [IDX_W-1:0] first, logic [IDX_W-1:0] last);
            t_split_res        res;
            logic [CODE_W-1:0] head;
            int unsigned       prefix;
            int unsigned       split;
            int unsigned       stride;
            int unsigned       probe;
            int unsigned       sh;
            res.split_index = '0;
            res.no_split    = 1'b1;
            // single element or reversed range
            if (first >= last) begin
                return res;
            end
            head   = codes[first];
            prefix = lead_zeros(head ^ codes[last]);
            // identical end codes
            if (prefix >= CODE_W) begin
                return res;
            end
            split  = first;
            stride = last - first;
            sh     = CODE_W - 1 - prefix;
            do begin
                stride = (stride + 1) >> 1;
                probe  = split + stride;
                if (probe < last) begin
                    if ((head >> sh) == (codes[probe] >> sh)) begin
                        split = probe;
                    end
                end
            end while (stride > 1);
            res.split_index = IDX_W'(split);
            res.no_split    = 1'b0;
            return res;
        endfunction

        // Last index of the written stretch that starts at from
        function int unsigned run_end(int unsigned from);
            int unsigned r;
            r = from;
            while (r + 1 < NUM_ENTRIES && written[r + 1]) begin
                r++;
            end
            return r;
        endfunction

        // Apply an accepted item: store a code, or queue the split it must produce
        function void note_item(t_action act, logic [IDX_W-1:0] li, logic [CODE_W-1:0] lc,
                                logic [IDX_W-1:0] rf, logic [IDX_W-1:0] rl);
            t_split_res res;
            if (act == A_LOAD) begin
                codes[li]   = lc;
                written[li] = 1'b1;
                loads++;
            end else begin
                res = predict_split(rf, rl);
                pending_splits.push_back(res);
                queries++;
                if (res.no_split) begin
                    quiet++;
                end else begin
                    splits++;
                end
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("MISMATCH at %0t: %s", $time, what);
            end
        endfunction

        // Compare one result against the oldest queued split
        function void check_result(logic [IDX_W-1:0] split_index, logic no_split);
            t_split_res want;
            checked++;
            if (pending_splits.size() == 0) begin
                flag($sformatf("unexpected result split_index=%0d no_split=%0b",
                               split_index, no_split));
                return;
            end
            want = pending_splits.pop_front();
            if (split_index !== want.split_index) begin
                flag($sformatf("split_index expected %0d, actual %0d",
                               want.split_index, split_index));
            end
            if (no_split !== want.no_split) begin
                flag($sformatf("no_split expected %0b, actual %0b", want.no_split, no_split));
            end
        endfunction
    endclass

endpackage

[tb/tb.sv]
// Top-level testbench for morton_split_search: drives loads and split queries, checks results.
`timescale 1ns / 1ps
module tb;
    import mss_pkg::*;
    import split_tracker_pkg::*;

    localparam int TOTAL_ITEMS    = 2000;
    localparam int HOLD_AFTER     = 120;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 32;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              i_action      = 1'b0;
    logic [IDX_W-1:0]  i_load_index  = '0;
    logic [CODE_W-1:0] i_load_code   = '0;
    logic [IDX_W-1:0]  i_range_first = '0;
    logic [IDX_W-1:0]  i_range_last  = '0;
    logic              i_ready       = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [IDX_W-1:0]  o_split_index;
    logic              o_no_split;

    split_tracker tracker = new();
    bit           send_burst = 1'b0;

    morton_split_search #(
        .MAX_PRIMS(NUM_ENTRIES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_load_index  (i_load_index),
        .i_load_code   (i_load_code),
        .i_range_first (i_range_first),
        .i_range_last  (i_range_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_split_index (o_split_index),
        .o_no_split    (o_no_split)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 17);
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input t_action act, input logic [IDX_W-1:0] li,
                             input logic [CODE_W-1:0] lc, input logic [IDX_W-1:0] rf,
                             input logic [IDX_W-1:0] rl);
        int unsigned gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_load_index  <= li;
        i_load_code   <= lc;
        i_range_first <= rf;
        i_range_last  <= rl;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_item(act, li, lc, rf, rl);
    endtask

    // Load one code; query fields carry noise
    task automatic put_code(input int unsigned idx, input logic [CODE_W-1:0] code);
        send_item(A_LOAD, IDX_W'(idx), code, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    // Query one range; load fields carry noise
    task automatic ask_split(input int unsigned first, input int unsigned last);
        send_item(A_QUERY, IDX_W'($urandom), $urandom, IDX_W'(first), IDX_W'(last));
    endtask

    // Fill base .. base+len-1 with ascending codes, duplicates, saturation or unsorted noise
    task automatic load_run(input int unsigned base, input int unsigned len);
        logic [CODE_W:0]   acc;
        logic [CODE_W-1:0] inc;
        logic [CODE_W-1:0] code;
        int unsigned       shape;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            acc = {1'b0, ~CODE_W'($urandom_range(0, 255))};
        end else begin
            acc = {1'b0, $urandom} >> $urandom_range(1, 32);
        end
        for (int unsigned k = 0; k < len; k++) begin
            if (k > 0 && shape != 1) begin
                case ($urandom_range(0, 4))
                    0: inc = '0;
                    1: inc = $urandom_range(1, 15);
                    2: inc = $urandom_range(1, 65536);
                    3: inc = $urandom >> $urandom_range(0, 31);
                    default: inc = $urandom_range(1, 3);
                endcase
                acc = acc + {1'b0, inc};
                if (acc[CODE_W]) begin
                    acc = {1'b0, {CODE_W{1'b1}}};
                end
            end
            code = (shape == 2) ? $urandom : acc[CODE_W-1:0];
            put_code(base + k, code);
        end
    endtask

    // Query inside a written run, sometimes reaching into older written entries
    task automatic ask_in_run(input int unsigned base, input int unsigned len);
        int unsigned first;
        int unsigned top;
        first = $urandom_range(base, base + len - 1);
        top   = ($urandom_range(0, 3) == 0) ? tracker.run_end(first) : base + len - 1;
        ask_split(first, $urandom_range(first, top));
    endtask

    // Result side: random stalls per item, plus one long hold to back up the block
    initial begin : result_sink
        int unsigned stall_left;
        bit          burst;
        bit          held;
        stall_left = $urandom_range(0, 17);
        burst      = 1'b0;
        held       = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                tracker.check_result(o_split_index, o_no_split);
                if ($urandom_range(0, 29) == 0) begin
                    burst = !burst;
                end
                stall_left = draw_gap(burst);
                if (!held && tracker.checked == HOLD_AFTER) begin
                    stall_left = HOLD_CYCLES;
                    held       = 1'b1;
                end
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_ready <= (stall_left == 0);
        end
    end

    // End the run when no item moves on either side for too long
    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Timeout: no item moved for %0d cycles", idle);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int unsigned first;
        int unsigned len;
        int unsigned base;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme codes and indexes, back to back
        send_burst = 1'b1;
        put_code(0, 32'h0000_0000);
        put_code(1, 32'h0000_0000);
        put_code(2, 32'h0000_0001);
        put_code(3, 32'h7FFF_FFFF);
        put_code(4, 32'h8000_0000);
        put_code(5, 32'hFFFF_FFFF);
        put_code(1021, 32'hFFFF_FFF0);
        put_code(1022, 32'hFFFF_FFFF);
        put_code(1023, 32'hFFFF_FFFF);
        ask_split(0, 1);        // identical end codes
        ask_split(0, 5);        // full prefix spread
        ask_split(0, 2);
        ask_split(2, 4);
        ask_split(3, 3);        // single element
        ask_split(5, 2);        // reversed range
        ask_split(1021, 1023);
        ask_split(1022, 1023);  // identical end codes at the top
        ask_split(1023, 0);     // reversed, widest
        ask_split(0, 0);
        ask_split(1023, 1023);
        put_code(6, 32'hFFFF_FFFF);
        ask_split(4, 6);        // query right behind the load it reads
        send_burst = 1'b0;

        // Random: mostly loaded runs followed by queries, some stray loads and bad ranges
        while (tracker.loads + tracker.queries < TOTAL_ITEMS) begin
            if ($urandom_range(0, 11) == 0) begin
                send_burst = !send_burst;
            end
            case ($urandom_range(0, 7))
                0: put_code($urandom_range(0, NUM_ENTRIES - 1), $urandom);
                1: begin
                    first = $urandom_range(0, NUM_ENTRIES - 1);
                    ask_split(first, $urandom_range(0, first));
                end
                default: begin
                    if ($urandom_range(0, 29) == 0) begin
                        len = $urandom_range(100, NUM_ENTRIES);
                    end else begin
                        len = $urandom_range(2, 24);
                    end
                    case ($urandom_range(0, 9))
                        0: base = 0;
                        1: base = NUM_ENTRIES - len;
                        default: base = $urandom_range(0, NUM_ENTRIES - len);
                    endcase
                    load_run(base, len);
                    repeat ($urandom_range(1, 6)) ask_in_run(base, len);
                end
            endcase
        end
        i_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (tracker.pending_splits.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d loads and %0d queries; %0d results gave a split, %0d gave none.",
                 tracker.loads, tracker.queries, tracker.splits, tracker.quiet);
        $display("Checked %0d results through one %0d-cycle receiver hold; %0d mismatches.",
                 tracker.checked, HOLD_CYCLES, tracker.mismatches);
        if (tracker.pending_splits.size() != 0) begin
            $display("%0d expected results never arrived", tracker.pending_splits.size());
        end
        if (tracker.mismatches == 0 && tracker.pending_splits.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
